// ===== hdl/qmc_v1_keystream_xor_macros.svh =====
// Assertion macros used by the keystream XOR checker.
`ifndef QMC_V1_KEYSTREAM_XOR_MACROS_SVH
`define QMC_V1_KEYSTREAM_XOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QKX_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qkx: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define QKX_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qkx: next-cycle check failed");

`endif

// ===== hdl/qkx_pkg.sv =====
// Shared widths, codes, defaults and helpers for the keystream XOR block.
package qkx_pkg;

  // Field widths
  localparam int OP_W        = 1;
  localparam int KEY_SLOT_W  = 9;
  localparam int BYTE_W      = 8;
  localparam int KEY_LEN_W   = 10;
  localparam int REM_W       = KEY_LEN_W + 1;

  // Parameter defaults
  localparam int KEY_DEPTH_DEF = 512;
  localparam int PAGE_SIZE_DEF = 32767;

  // Stream offsets
  localparam int OFF_W = 17;
  localparam logic [OFF_W-1:0] OFF_STATIC = 17'd80923;
  localparam logic [OFF_W-1:0] OFF_MAP    = 17'd71214;

  // Shift amount bias for the map-mode shift-or
  localparam logic [2:0] SHIFT_BIAS = 3'd4;

  // Item operation codes
  localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
  localparam logic [OP_W-1:0] OP_DATA = 1'b1;

  // APB register map
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_KEY_LENGTH  = 1'b0;
  localparam logic REG_CIPHER_MODE = 1'b1;

  // Map-mode transform: left shift masked to a byte, OR right shift (not a rotate)
  function automatic logic [BYTE_W-1:0] shift_or(input logic [BYTE_W-1:0] v,
                                                 input logic [2:0] s);
    shift_or = (v << s) | (v >> s);
  endfunction

endpackage

// ===== hdl/qkx_if.sv =====
// Valid/ready channel interfaces for key/data items and decrypted results.
interface qkx_item_if;
  import qkx_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       op;
  logic [KEY_SLOT_W-1:0] key_slot;
  logic [BYTE_W-1:0]     key_value;
  logic [BYTE_W-1:0]     cipher_byte;

  modport source (output valid, op, key_slot, key_value, cipher_byte, input ready);
  modport sink   (input valid, op, key_slot, key_value, cipher_byte, output ready);
endinterface

interface qkx_result_if;
  import qkx_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] plain_byte;
  logic              no_key_error;

  modport source (output valid, plain_byte, no_key_error, input ready);
  modport sink   (input valid, plain_byte, no_key_error, output ready);
endinterface

// ===== hdl/qmc_v1_keystream_xor.sv =====
// Keystream XOR decryptor: key store loads and per-byte keystream lookup.
// Key load item: taken while idle, the input stays ready, no result.
// Data item: steps through SQUARE, DIVIDE, READ and OUT, where DIVIDE waits on the
//   bit-serial mod unit with dividend width DW; the next item is taken after the result loads.
// No-key data item: goes straight to OUT and gives an error result.
// rst (synchronous) clears position, registers and sequencer; the key store is not cleared.
module qmc_v1_keystream_xor #(
  parameter int KEY_DEPTH = qkx_pkg::KEY_DEPTH_DEF,
  parameter int PAGE_SIZE = qkx_pkg::PAGE_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  qkx_item_if.sink                    item,
  qkx_result_if.source                result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qkx_pkg::PADDR_W-1:0] paddr,
  input  logic [qkx_pkg::PDATA_W-1:0] pwdata,
  output logic [qkx_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import qkx_pkg::*;

  localparam int AW   = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int PW   = $clog2(PAGE_SIZE + 1);
  localparam int SQ_W = 2 * PW;
  localparam int DW   = ((SQ_W > OFF_W) ? SQ_W : OFF_W) + 1;
  localparam logic [PW-1:0] POS_RESTART = PW'(1 % PAGE_SIZE);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SQUARE = 5'b00010,
    S_DIVIDE = 5'b00100,
    S_READ   = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [KEY_LEN_W-1:0] key_length;
  logic                 cipher_mode;
  logic [PW-1:0]        pos;
  logic                 first_done;
  logic [BYTE_W-1:0]    cipher;
  logic                 err;

  logic [KEY_LEN_W-1:0] n_eff;
  logic [OFF_W-1:0]     offset;
  logic [SQ_W-1:0]      square;
  logic [DW-1:0]        dividend;
  logic                 div_done;
  logic [REM_W-1:0]     key_index;
  logic [BYTE_W-1:0]    key_byte;
  logic [BYTE_W-1:0]    stream;
  logic [PW:0]          pos_inc;
  logic                 item_xfer;
  logic                 out_load;
  logic                 cfg_write;
  logic                 key_we;

  // APB register file
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length  <= '0;
      cipher_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_KEY_LENGTH:  key_length  <= pwdata[KEY_LEN_W-1:0];
        REG_CIPHER_MODE: cipher_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_KEY_LENGTH:  prdata = PDATA_W'(key_length);
      REG_CIPHER_MODE: prdata = PDATA_W'(cipher_mode);
      default:         prdata = '0;
    endcase
  end

  // effective key length, clamped to the store depth
  assign n_eff  = (32'(key_length) > KEY_DEPTH) ? KEY_LEN_W'(KEY_DEPTH) : key_length;
  assign offset = cipher_mode ? OFF_MAP : OFF_STATIC;

  // square of the stream position plus offset feeds the mod unit
  assign square   = SQ_W'(pos) * SQ_W'(pos);
  assign dividend = DW'(square) + DW'(offset);

  qkx_divmod #(.DW(DW)) u_divmod (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_SQUARE),
    .dividend (dividend),
    .divisor  (n_eff),
    .done     (div_done),
    .remainder(key_index)
  );

  // key store
  assign item_xfer = item.valid && item.ready;
  assign key_we    = item_xfer && (item.op == OP_LOAD) && (32'(item.key_slot) < KEY_DEPTH);

  qkx_ram #(.WIDTH(BYTE_W), .DEPTH(KEY_DEPTH)) u_key_store (
    .clk  (clk),
    .we   (key_we),
    .waddr(AW'(item.key_slot)),
    .wdata(item.key_value),
    .re   (state == S_READ),
    .raddr(AW'(key_index)),
    .rdata(key_byte)
  );

  // keystream byte, with the map-mode shift-or
  assign stream = cipher_mode ? shift_or(key_byte, key_index[2:0] + SHIFT_BIAS) : key_byte;

  // sequencer
  assign item.ready = (state == S_IDLE);
  assign out_load   = (state == S_OUT) && (!result.valid || result.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_xfer && (item.op == OP_DATA)) begin
          state_next = (n_eff == '0) ? S_OUT : S_SQUARE;
        end
      end
      S_SQUARE: state_next = S_DIVIDE;
      S_DIVIDE: begin
        if (div_done) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (item_xfer && (item.op == OP_DATA)) begin
      cipher <= item.cipher_byte;
      err    <= (n_eff == '0);
    end
  end

  // stream position: first page runs 0..PAGE_SIZE, then cycles mod PAGE_SIZE
  assign pos_inc = {1'b0, pos} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      first_done <= 1'b0;
    end else if (out_load && !err) begin
      if (!first_done) begin
        if ({1'b0, pos} >= (PW+1)'(PAGE_SIZE)) begin
          first_done <= 1'b1;
          pos        <= POS_RESTART;
        end else begin
          pos <= pos_inc[PW-1:0];
        end
      end else begin
        pos <= (pos_inc >= (PW+1)'(PAGE_SIZE)) ? '0 : pos_inc[PW-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.plain_byte   <= err ? '0 : (cipher ^ stream);
      result.no_key_error <= err;
    end
  end

endmodule

// ===== hdl/qkx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module qkx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/qkx_divmod.sv =====
// Bit-serial restoring remainder unit: dividend mod divisor, one bit per cycle.
module qkx_divmod #(
  parameter int DW = 31
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [DW-1:0]                 dividend,
  input  logic [qkx_pkg::KEY_LEN_W-1:0] divisor,
  output logic                          done,
  output logic [qkx_pkg::REM_W-1:0]     remainder
);
  import qkx_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0]    shift;
  logic [CW-1:0]    count;
  logic             busy;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] rem_next;

  // one trial subtract per cycle
  assign trial = {remainder[REM_W-2:0], shift[DW-1]};
  assign rem_next = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(DW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      shift     <= dividend;
      remainder <= '0;
    end else if (busy) begin
      shift     <= shift << 1;
      remainder <= rem_next;
    end
  end

endmodule

// ===== hdl/qkx_checker.sv =====
// Port-level checker for the keystream XOR block, bound to the top level.
`include "qmc_v1_keystream_xor_macros.svh"

module qkx_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_ready,
  input logic [qkx_pkg::OP_W-1:0]    item_op,
  input logic                        result_valid,
  input logic                        result_ready,
  input logic [qkx_pkg::BYTE_W-1:0]  plain_byte,
  input logic                        no_key_error
);
  import qkx_pkg::*;

  // a stalled result holds
  `QKX_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(plain_byte) && $stable(no_key_error))

  // a data transfer makes the block busy
  `QKX_ASSERT_NEXT(a_data_busy, clk, rst, item_valid && item_ready && (item_op == OP_DATA), !item_ready)

  // a key load never stalls the input
  `QKX_ASSERT_NEXT(a_load_ready, clk, rst, item_valid && item_ready && (item_op == OP_LOAD), item_ready)

  // an error result carries no plaintext
  `QKX_ASSERT_SAME(a_error_zero, clk, rst, result_valid && no_key_error, plain_byte == '0)

endmodule

bind qmc_v1_keystream_xor qkx_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item.valid),
  .item_ready  (item.ready),
  .item_op     (item.op),
  .result_valid(result.valid),
  .result_ready(result.ready),
  .plain_byte  (result.plain_byte),
  .no_key_error(result.no_key_error)
);
